FILE: sv/assert_macros.svh
// assertion macros used by the checker file ddo_checker.sv
// no dependencies; pull in with an include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry block
// no dependencies; used by controller, datapath, top level and checker
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int CFG_IDX_W = 8;
	localparam int GAIN_W = 24;
	localparam int VEL_W = 16;
	localparam int POS_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = 8'd1;

	// angle constants, Q3.28 radians
	localparam logic signed [32:0] PI_Q28 = 33'sd843314857;
	localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629713;
	localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic signed [31:0] TWO_PI_H = 32'sd1686629713;
	localparam logic signed [47:0] TWO_PI_W = 48'sd1686629713;
	// 1/K of the cordic gain, Q2.30
	localparam logic signed [31:0] CORDIC_INV_K = 32'sd652032874;

	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	// datapath micro-operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_MUL_L = 4'd2;
	localparam op_t OP_MUL_R = 4'd3;
	localparam op_t OP_TRAV  = 4'd4;
	localparam op_t OP_MUL_T = 4'd5;
	localparam op_t OP_DTH   = 4'd6;
	localparam op_t OP_MID   = 4'd7;
	localparam op_t OP_RED   = 4'd8;
	localparam op_t OP_FOLD  = 4'd9;
	localparam op_t OP_ROT   = 4'd10;
	localparam op_t OP_FLIP  = 4'd11;
	localparam op_t OP_MUL_C = 4'd12;
	localparam op_t OP_MUL_S = 4'd13;
	localparam op_t OP_UPD   = 4'd14;
	localparam op_t OP_OUT   = 4'd15;

	typedef logic [4:0] iter_t;

	typedef struct packed {
		op_t   op;
		iter_t iter;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	// arctangent of 2^-i, Q2.30
	function automatic logic signed [31:0] atan_q30(input iter_t i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:  r = 32'sd843314856;
			5'd1:  r = 32'sd497837829;
			5'd2:  r = 32'sd263043836;
			5'd3:  r = 32'sd133525158;
			5'd4:  r = 32'sd67021686;
			5'd5:  r = 32'sd33543515;
			5'd6:  r = 32'sd16775850;
			5'd7:  r = 32'sd8388437;
			5'd8:  r = 32'sd4194282;
			5'd9:  r = 32'sd2097149;
			5'd10: r = 32'sd1048575;
			5'd11: r = 32'sd524287;
			5'd12: r = 32'sd262143;
			5'd13: r = 32'sd131071;
			5'd14: r = 32'sd65535;
			5'd15: r = 32'sd32767;
			5'd16: r = 32'sd16383;
			5'd17: r = 32'sd8191;
			5'd18: r = 32'sd4095;
			5'd19: r = 32'sd2047;
			5'd20: r = 32'sd1023;
			5'd21: r = 32'sd511;
			5'd22: r = 32'sd255;
			5'd23: r = 32'sd127;
			5'd24: r = 32'sd63;
			5'd25: r = 32'sd31;
			5'd26: r = 32'sd15;
			5'd27: r = 32'sd8;
			5'd28: r = 32'sd4;
			5'd29: r = 32'sd2;
			5'd30: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = $signed(v[31:0]);
		end
		return r;
	endfunction

endpackage

FILE: sv/differential_drive_odometry.sv
// differential drive odometry: each input runs through the multiply, angle, cordic and update
// phases before m_tvalid rises; a new item is taken only when idle, once the last result is registered
// the item rate is set by the cordic loop (one rotation per cycle) and one shared 31x32 multiplier
// a finished result waits in the output register while the next item is already taken
// arst_n clears position, heading, both gains and the output valid; no clearing pass
// depends on ddo_pkg, ddo_ctrl and ddo_datapath
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream, one transfer per control tick
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // left_velocity [15:0], right_velocity [31:16]
	// result stream, one transfer per tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // pos_x [31:0], pos_y [63:32], heading [95:64]
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddo_pkg::GAIN_W-1:0]    cfg_data
);

	ddo_pkg::cmd_t cmd;
	ddo_pkg::sts_t sts;

	// gains are to be only written between ticks; the block does not enforce it, so writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer: steps one tick through multiply, angle, cordic and update phases
	ddo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: holds the pose, the gains and the output register
	ddo_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: sv/ddo_ctrl.sv
// sequencer for one odometry tick: multiplies, angle reduction, cordic loop, update
// depends on ddo_pkg for command and status types
module ddo_ctrl #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ddo_pkg::sts_t sts,
	output ddo_pkg::cmd_t cmd
);

	localparam int ITER_W = $clog2(CORDIC_STEPS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_L = 4'd1;
	localparam logic [3:0] ST_MUL_R = 4'd2;
	localparam logic [3:0] ST_TRAV  = 4'd3;
	localparam logic [3:0] ST_MUL_T = 4'd4;
	localparam logic [3:0] ST_DTH   = 4'd5;
	localparam logic [3:0] ST_MID   = 4'd6;
	localparam logic [3:0] ST_RED   = 4'd7;
	localparam logic [3:0] ST_FOLD  = 4'd8;
	localparam logic [3:0] ST_ROT   = 4'd9;
	localparam logic [3:0] ST_FLIP  = 4'd10;
	localparam logic [3:0] ST_MUL_C = 4'd11;
	localparam logic [3:0] ST_MUL_S = 4'd12;
	localparam logic [3:0] ST_UPD   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0]        state_q, state_d;
	logic [ITER_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.op   = ddo_pkg::OP_NONE;
		cmd.iter = ddo_pkg::iter_t'(cnt_q);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = ddo_pkg::OP_LOAD;
					state_d = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				cmd.op  = ddo_pkg::OP_MUL_L;
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				cmd.op  = ddo_pkg::OP_MUL_R;
				state_d = ST_TRAV;
			end
			ST_TRAV: begin
				cmd.op  = ddo_pkg::OP_TRAV;
				state_d = ST_MUL_T;
			end
			ST_MUL_T: begin
				cmd.op  = ddo_pkg::OP_MUL_T;
				state_d = ST_DTH;
			end
			ST_DTH: begin
				cmd.op  = ddo_pkg::OP_DTH;
				state_d = ST_MID;
			end
			ST_MID: begin
				cmd.op  = ddo_pkg::OP_MID;
				state_d = ST_RED;
			end
			ST_RED: begin
				cmd.op  = ddo_pkg::OP_RED;
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.op  = ddo_pkg::OP_FOLD;
				cnt_d   = '0;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.op = ddo_pkg::OP_ROT;
				if (cnt_q == ITER_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_FLIP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FLIP: begin
				cmd.op  = ddo_pkg::OP_FLIP;
				state_d = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.op  = ddo_pkg::OP_MUL_C;
				state_d = ST_MUL_S;
			end
			ST_MUL_S: begin
				cmd.op  = ddo_pkg::OP_MUL_S;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.op  = ddo_pkg::OP_UPD;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.op  = ddo_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

FILE: sv/ddo_datapath.sv
// odometry datapath: gain registers, shared multiplier, cordic rotator, accumulators
// depends on ddo_pkg for constants, tables and command types
module ddo_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  ddo_pkg::cmd_t cmd,
	output ddo_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddo_pkg::GAIN_W-1:0]    cfg_data,
	input  logic [31:0]   in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [95:0]   out_data
);

	logic [ddo_pkg::GAIN_W-1:0] wg_q, tg_q;
	logic signed [31:0] x_q, y_q, heading_q;
	logic               out_valid_q;

	logic signed [15:0] vl_q, vr_q;
	logic signed [62:0] prod_q;
	logic signed [29:0] tl_q, tr_q, step_q;
	logic signed [31:0] dth_q;
	logic signed [32:0] mid_q, h_q;
	logic signed [33:0] z_q;
	logic signed [31:0] cx_q, cy_q;
	logic               flip_q;
	logic [95:0]        out_q;

	logic signed [30:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [62:0] mul_p;
	logic signed [30:0] tsum, tdiff;
	logic signed [47:0] dth_full;
	logic signed [32:0] mid_red, h_wrap, phi;
	logic               phi_flip;
	logic signed [31:0] xs, ys, atan_v;
	logic signed [33:0] acc_sum;

	// shared multiplier operand select
	always_comb begin
		tdiff = 31'(tr_q) - 31'(tl_q);
		tsum  = 31'(tl_q) + 31'(tr_q);
		mul_a = 31'(vl_q);
		mul_b = $signed({8'd0, wg_q});
		unique case (cmd.op)
			ddo_pkg::OP_MUL_R: begin
				mul_a = 31'(vr_q);
			end
			ddo_pkg::OP_MUL_T: begin
				mul_a = tdiff;
				mul_b = $signed({8'd0, tg_q});
			end
			ddo_pkg::OP_MUL_C: begin
				mul_a = 31'(step_q);
				mul_b = cx_q;
			end
			ddo_pkg::OP_MUL_S: begin
				mul_a = 31'(step_q);
				mul_b = cy_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		dth_full = $signed(prod_q[55:8]);

		// reduce the mid angle into about (-pi, pi]
		mid_red = mid_q;
		if (mid_q > ddo_pkg::PI_Q28) begin
			mid_red = mid_q - ddo_pkg::TWO_PI_Q28;
		end else if (mid_q <= -ddo_pkg::PI_Q28) begin
			mid_red = mid_q + ddo_pkg::TWO_PI_Q28;
		end

		h_wrap = h_q;
		if (h_q >= ddo_pkg::TWO_PI_Q28) begin
			h_wrap = h_q - ddo_pkg::TWO_PI_Q28;
		end else if (h_q <= -ddo_pkg::TWO_PI_Q28) begin
			h_wrap = h_q + ddo_pkg::TWO_PI_Q28;
		end

		// fold into [-pi/2, pi/2], flipping both outputs
		phi      = mid_q;
		phi_flip = 1'b0;
		if (mid_q > ddo_pkg::HALF_PI_Q28) begin
			phi      = mid_q - ddo_pkg::PI_Q28;
			phi_flip = 1'b1;
		end else if (mid_q < -ddo_pkg::HALF_PI_Q28) begin
			phi      = mid_q + ddo_pkg::PI_Q28;
			phi_flip = 1'b1;
		end

		xs     = cx_q >>> cmd.iter;
		ys     = cy_q >>> cmd.iter;
		atan_v = ddo_pkg::atan_q30(cmd.iter);

		// accumulator add for x (from step*cos) or y (from step*sin)
		if (cmd.op == ddo_pkg::OP_MUL_S) begin
			acc_sum = 34'(x_q) + 34'($signed(prod_q[62:30]));
		end else begin
			acc_sum = 34'(y_q) + 34'($signed(prod_q[62:30]));
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ddo_pkg::OP_LOAD: begin
				vl_q <= $signed(in_data[15:0]);
				vr_q <= $signed(in_data[31:16]);
			end
			ddo_pkg::OP_MUL_L: begin
				prod_q <= mul_p;
			end
			ddo_pkg::OP_MUL_R: begin
				tl_q   <= $signed(prod_q[39:10]);
				prod_q <= mul_p;
			end
			ddo_pkg::OP_TRAV: begin
				tr_q <= $signed(prod_q[39:10]);
			end
			ddo_pkg::OP_MUL_T: begin
				prod_q <= mul_p;
				step_q <= $signed(tsum[30:1]);
			end
			ddo_pkg::OP_DTH: begin
				if (dth_full > ddo_pkg::TWO_PI_W) begin
					dth_q <= ddo_pkg::TWO_PI_H;
				end else if (dth_full < -ddo_pkg::TWO_PI_W) begin
					dth_q <= -ddo_pkg::TWO_PI_H;
				end else begin
					dth_q <= $signed(dth_full[31:0]);
				end
			end
			ddo_pkg::OP_MID: begin
				mid_q <= 33'(heading_q) + 33'(dth_q >>> 1);
				h_q   <= 33'(heading_q) + 33'(dth_q);
			end
			ddo_pkg::OP_RED: begin
				mid_q <= mid_red;
				h_q   <= h_wrap;
			end
			ddo_pkg::OP_FOLD: begin
				z_q    <= $signed({phi[31:0], 2'b00});
				flip_q <= phi_flip;
				cx_q   <= ddo_pkg::CORDIC_INV_K;
				cy_q   <= '0;
			end
			ddo_pkg::OP_ROT: begin
				if (z_q >= 0) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - 34'(atan_v);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + 34'(atan_v);
				end
			end
			ddo_pkg::OP_FLIP: begin
				if (flip_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			ddo_pkg::OP_MUL_C: begin
				prod_q <= mul_p;
			end
			ddo_pkg::OP_MUL_S: begin
				prod_q <= mul_p;
			end
			ddo_pkg::OP_OUT: begin
				out_q <= {heading_q, y_q, x_q};
			end
			default: begin
			end
		endcase
	end

	// architectural state and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wg_q        <= '0;
			tg_q        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_pkg::REG_WHEEL_GAIN: wg_q <= cfg_data;
					ddo_pkg::REG_TURN_GAIN:  tg_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == ddo_pkg::OP_MUL_S) begin
				x_q <= ddo_pkg::sat32(acc_sum);
			end
			if (cmd.op == ddo_pkg::OP_UPD) begin
				y_q       <= ddo_pkg::sat32(acc_sum);
				heading_q <= ddo_pkg::sat32(34'(h_q));
			end
			if (cmd.op == ddo_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

FILE: sv/ddo_checker.sv
// port-level checks for the odometry block, bound to the top level
// depends on ddo_pkg and assert_macros.svh
`include "assert_macros.svh"

module ddo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	logic signed [31:0] hd;
	logic               hd_ok;
	assign hd    = $signed(m_tdata[95:64]);
	assign hd_ok = (hd < ddo_pkg::TWO_PI_H) && (hd > -ddo_pkg::TWO_PI_H);

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// a stalled result keeps its value
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// one tick at a time: input closes right after a transfer
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// wrapped heading stays strictly inside one turn either way
	`ASSERT_IMPLIES(a_heading_range, clk, arst_n, m_tvalid, hd_ok)

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
